// File: hw/rtl/rid_pkg.sv
// package with widths, pipeline item type and the restoring round function
`timescale 1ns / 1ps
`default_nettype none

package rid_pkg;

    localparam int DIVIDEND_WIDTH = 16;
    localparam int DIVISOR_WIDTH  = 16;
    // one restoring round per pipeline stage
    localparam int NUM_STAGES     = DIVIDEND_WIDTH;

    // data carried down the pipeline
    // nq holds the dividend bits still to enter on top, quotient bits collect at the bottom
    typedef struct packed {
        logic [DIVISOR_WIDTH-1:0]  rem;
        logic [DIVIDEND_WIDTH-1:0] nq;
        logic [DIVISOR_WIDTH-1:0]  dvs;
    } t_item;

    // one restoring round: shift in next dividend bit, trial subtract with borrow
    function automatic t_item rid_round(input t_item cur);
        logic [DIVISOR_WIDTH-1:0] shifted;
        logic [DIVISOR_WIDTH:0]   diff;
        logic                     fits;
        t_item                    nxt;
        shifted = {cur.rem[DIVISOR_WIDTH-2:0], cur.nq[DIVIDEND_WIDTH-1]};
        diff    = {cur.rem[DIVISOR_WIDTH-1], shifted} - {1'b0, cur.dvs};
        fits    = ~diff[DIVISOR_WIDTH];
        nxt.rem = fits ? diff[DIVISOR_WIDTH-1:0] : shifted;
        nxt.nq  = {cur.nq[DIVIDEND_WIDTH-2:0], fits};
        nxt.dvs = cur.dvs;
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rid_stage.sv
// one pipeline stage: a restoring round followed by a valid/ready register
`timescale 1ns / 1ps
`default_nettype none

module rid_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rid_pkg::t_item i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rid_pkg::t_item     o_item
);
    import rid_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  load;

    // stage takes a transfer when empty or when its content moves on
    assign o_ready = ~r_valid | i_ready;
    assign load    = i_valid & o_ready;

    // valid bit follows the data
    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= rid_round(i_item);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: hw/rtl/restoring_integer_divider_unit.sv
// top level of the pipelined restoring divider
// the result passes through the chain of stage registers, one restoring round per stage
// throughput: one division per cycle while the output is not stalled; each stage holds one item and
// stalls only when full and its successor cannot take a transfer; the last stage is the output register
// reset: synchronous active-low, clears every stage valid bit, payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module restoring_integer_divider_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [rid_pkg::DIVIDEND_WIDTH-1:0] i_dividend,
    input  wire logic [rid_pkg::DIVISOR_WIDTH-1:0]  i_divisor,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [rid_pkg::DIVIDEND_WIDTH-1:0]      o_quotient,
    output logic [rid_pkg::DIVISOR_WIDTH-1:0]       o_remainder_value
);
    import rid_pkg::*;

    logic  stg_valid [0:NUM_STAGES];
    logic  stg_ready [0:NUM_STAGES];
    t_item stg_item  [0:NUM_STAGES];

    // entry point: remainder starts at zero
    assign stg_valid[0]    = i_valid;
    assign o_ready         = stg_ready[0];
    assign stg_item[0].rem = '0;
    assign stg_item[0].nq  = i_dividend;
    assign stg_item[0].dvs = i_divisor;

    // one stage per round
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        rid_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_item  (stg_item[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_item  (stg_item[g+1])
        );
    end

    // result side
    assign stg_ready[NUM_STAGES] = i_ready;
    assign o_valid               = stg_valid[NUM_STAGES];
    assign o_quotient            = stg_item[NUM_STAGES].nq;
    assign o_remainder_value     = stg_item[NUM_STAGES].rem;

endmodule

`default_nettype wire

// File: hw/rtl/rid_checker.sv
// port-level checker for the restoring divider, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rid_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic                               o_ready,
    input  wire logic [rid_pkg::DIVIDEND_WIDTH-1:0] i_dividend,
    input  wire logic [rid_pkg::DIVISOR_WIDTH-1:0]  i_divisor,
    input  wire logic                               o_valid,
    input  wire logic                               i_ready,
    input  wire logic [rid_pkg::DIVIDEND_WIDTH-1:0] o_quotient,
    input  wire logic [rid_pkg::DIVISOR_WIDTH-1:0]  o_remainder_value
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quotient) && $stable(o_remainder_value))
        else $error("stalled result changed or dropped");

    // with no result waiting the pipeline can always take a transfer
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

    // a moving output never blocks the input
    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output drains");

endmodule

bind restoring_integer_divider_unit rid_checker u_rid_checker (.*);

`default_nettype wire

// File: tb/restoring_integer_divider_unit_tb.sv
// testbench for the pipelined restoring divider: random stalls, scoreboard check of quotient and remainder
`timescale 1ns / 1ps

module restoring_integer_divider_unit_tb;

    localparam int DW             = rid_pkg::DIVIDEND_WIDTH;
    localparam int SW             = rid_pkg::DIVISOR_WIDTH;
    localparam int NUM_STAGES     = rid_pkg::NUM_STAGES;
    localparam int NMAX           = (1 << DW) - 1;
    localparam int DMAX           = (1 << SW) - 1;
    localparam int RANDOM_ITEMS   = 1830;
    localparam int HOLDOFF_CYCLES = 160;
    localparam int CYCLE_LIMIT    = 500000;

    typedef struct {
        logic [DW-1:0] quotient;
        logic [SW-1:0] remainder_value;
    } t_division_result;

    // expected quotient/remainder pairs, oldest first
    class division_scoreboard;
        t_division_result expected_results[$];
        int               mismatch_count;
        int               results_seen;

        function new();
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        // restoring division with a one-bit-wider trial subtraction
        function t_division_result divide(input logic [DW-1:0] n, input logic [SW-1:0] d);
            logic [SW:0]      widened;
            logic [SW-1:0]    partial;
            logic [DW-1:0]    q;
            int               bit_idx;
            t_division_result res;
            partial = '0;
            q       = '0;
            for (bit_idx = DW - 1; bit_idx >= 0; bit_idx--) begin
                widened = {partial, n[bit_idx]};
                if (widened >= {1'b0, d}) begin
                    widened = widened - {1'b0, d};
                    q       = {q[DW-2:0], 1'b1};
                end else begin
                    q       = {q[DW-2:0], 1'b0};
                end
                partial = widened[SW-1:0];
            end
            res.quotient        = q;
            res.remainder_value = partial;
            return res;
        endfunction

        function void note_operands(input logic [DW-1:0] n, input logic [SW-1:0] d);
            expected_results.push_back(divide(n, d));
        endfunction

        function void check_result(input logic [DW-1:0] q, input logic [SW-1:0] r);
            t_division_result exp_res;
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result q=%0d r=%0d", $time, q, r);
                mismatch_count++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (q !== exp_res.quotient) begin
                $display("%0t: quotient expected %0d actual %0d", $time, exp_res.quotient, q);
                mismatch_count++;
            end
            if (r !== exp_res.remainder_value) begin
                $display("%0t: remainder expected %0d actual %0d",
                         $time, exp_res.remainder_value, r);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [DW-1:0] i_dividend;
    logic [SW-1:0] i_divisor;
    logic          o_valid;
    logic          i_ready;
    logic [DW-1:0] o_quotient;
    logic [SW-1:0] o_remainder_value;

    division_scoreboard sb;
    int                 cycle_count;

    restoring_integer_divider_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_dividend        (i_dividend),
        .i_divisor         (i_divisor),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_quotient        (o_quotient),
        .o_remainder_value (o_remainder_value)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short idle gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // offer one division, hold it until the transfer happens
    task automatic send_division(input int n, input int d, input int gap);
        repeat (gap) @(negedge i_clk) i_valid = 1'b0;
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_dividend = DW'(n);
        i_divisor  = SW'(d);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random operands shaped toward the interesting corners
    task automatic send_random_division(input int gap);
        int n;
        int d;
        case ($urandom_range(0, 9))
            4: begin
                n = $urandom_range(0, NMAX);
                d = $urandom_range(1, 15);
            end
            5: begin
                n = $urandom_range(0, NMAX);
                d = $urandom_range(1 << (SW - 1), DMAX);
            end
            6: begin
                d = $urandom_range(1, DMAX);
                n = $urandom_range(0, d - 1);
            end
            7: begin
                d = $urandom_range(1, 300);
                n = d * $urandom_range(0, NMAX / d);
            end
            8: begin
                n = $urandom_range(0, NMAX);
                d = ($urandom_range(0, 1) == 0) ? 0 : DMAX;
            end
            9: begin
                n = $urandom_range(0, NMAX);
                d = 1 << $urandom_range(0, SW - 1);
            end
            default: begin
                n = $urandom_range(0, NMAX);
                d = $urandom_range(0, DMAX);
            end
        endcase
        send_division(n, d, gap);
    endtask

    // transfers on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_operands(i_dividend, i_divisor);
            if (o_valid && i_ready) sb.check_result(o_quotient, o_remainder_value);
        end
    end

    // receiver: ready bursts and stalls, two long hold-offs to back up the pipeline
    initial begin : receiver
        int ready_run;
        int stall;
        int holdoffs_done;
        i_ready       = 1'b0;
        holdoffs_done = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 12);
            stall     = pick_gap();
            if ((holdoffs_done == 0 && sb.results_seen >= 300) ||
                (holdoffs_done == 1 && sb.results_seen >= 1200)) begin
                stall = HOLDOFF_CYCLES;
                holdoffs_done++;
            end
            repeat (ready_run) @(negedge i_clk) i_ready = 1'b1;
            repeat (stall) @(negedge i_clk) i_ready = 1'b0;
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // reset, directed divisions, random divisions, drain
    initial begin : stimulus
        int item_idx;
        int gap;
        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_dividend = '0;
        i_divisor  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // zero divisor, divisors with the top bit set, operand extremes
        send_division(0, 0, 0);
        send_division(NMAX, 0, 0);
        send_division(1234, 0, 0);
        send_division(0, 1, 0);
        send_division(NMAX, 1, 0);
        send_division(0, DMAX, 0);
        send_division(NMAX, DMAX, 0);
        send_division(NMAX - 1, DMAX, 1);
        send_division(1 << (DW - 1), 1 << (SW - 1), 0);
        send_division(NMAX, 1 << (SW - 1), 0);
        send_division((1 << (DW - 1)) - 1, 1 << (SW - 1), 2);
        send_division(NMAX, (1 << (SW - 1)) - 1, 0);
        send_division(40000, 40001, 0);
        send_division(40001, 40000, 0);
        send_division(100, 7, 5);
        send_division(7, 100, 0);
        send_division(NMAX, 2, 0);
        send_division(16'haaaa, 16'h5555, 0);
        send_division(16'h5555, 16'haaaa, 0);
        send_division(1, 1, 0);
        send_division(12345, 12345, 3);
        send_division(1 << (DW - 1), 1, 0);

        for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
            gap = ((item_idx / 128) % 3 == 1) ? 0 : pick_gap();
            send_random_division(gap);
        end
        @(negedge i_clk) i_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * NUM_STAGES + 4) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
